// File: design/double_round_to_integral_macros.svh
// Assertion macros for the round-to-integral block
`ifndef DOUBLE_ROUND_TO_INTEGRAL_MACROS_SVH
`define DOUBLE_ROUND_TO_INTEGRAL_MACROS_SVH
`define DRI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: label failed");
`define DRI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: label failed");
`endif

// File: design/dri_pkg.sv
// Package: constants, types and rounding function for the round-to-integral block
package dri_pkg;
	localparam int unsigned MantBits = 52;
	localparam logic [10:0] ExpBias = 11'd1023;
	localparam logic [63:0] OneBits = 64'h3FF0_0000_0000_0000;

	typedef enum logic [1:0] {
		OP_FLOOR = 2'd0,
		OP_CEIL  = 2'd1,
		OP_TRUNC = 2'd2,
		OP_ROUND = 2'd3
	} op_t;

	function automatic logic [63:0] round_bits(input logic [63:0] bits, input op_t op);
		logic [10:0] ex;
		logic        neg;
		logic [5:0]  fb;
		logic [63:0] unit_v;
		logic [63:0] mask;
		logic [63:0] whole;
		logic        bump;
		logic        to_one;
		ex = bits[62:52];
		neg = bits[63];
		fb = 6'(11'(ExpBias + 11'(MantBits)) - ex);
		unit_v = 64'd1 << fb;
		mask = unit_v - 64'd1;
		whole = bits & ~mask;
		unique case (op)
			OP_FLOOR: begin bump = neg; to_one = neg; end
			OP_CEIL: begin bump = !neg; to_one = !neg; end
			OP_TRUNC: begin bump = 1'b0; to_one = 1'b0; end
			OP_ROUND: begin
				bump = |(bits & (unit_v >> 1));
				to_one = (ex == 11'(ExpBias - 11'd1));
			end
			default: begin bump = 1'b0; to_one = 1'b0; end
		endcase
		if (ex >= 11'(ExpBias + 11'(MantBits)) || bits[62:0] == 63'd0) begin
			return bits;
		end else if (ex < ExpBias) begin
			return {neg, 63'd0} | (to_one ? OneBits : 64'd0);
		end else if ((bits & mask) == 64'd0) begin
			return bits;
		end
		return bump ? whole + unit_v : whole;
	endfunction
endpackage

// File: design/dri_core.sv
// Rounding datapath between the input register and the result register
module dri_core import dri_pkg::*; (
	input  logic [1:0]  op_s1,
	input  logic [63:0] bits_s1,
	output logic [63:0] result
);
	assign result = round_bits(bits_s1, op_t'(op_s1));
endmodule

// File: design/double_round_to_integral.sv
// Round-to-integral unit for IEEE-754 doubles: floor, ceil, truncate, round half away.
// One word enters per cycle while in_ready is high; an accepted word passes from the input
// register through the rounding datapath into the result register. The result register
// advances when it is empty or taken; the input register also loads whenever it is empty.
// NaN, infinity and magnitudes of 2^52 or more pass through unchanged; signs are kept.
module double_round_to_integral import dri_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [63:0] value_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_bits
);
	logic        vld_s1, vld_s2;
	logic [1:0]  op_s1;
	logic [63:0] bits_s1, res_s2, res_c;
	logic        adv;

	assign adv = !vld_s2 || out_ready;
	assign in_ready = adv || !vld_s1;

	dri_core u_core (.op_s1(op_s1), .bits_s1(bits_s1), .result(res_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv) vld_s2 <= vld_s1;
			if (in_ready) vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) res_s2 <= res_c;
		if (in_ready && in_valid) begin
			op_s1 <= operation;
			bits_s1 <= value_bits;
		end
	end

	assign out_valid = vld_s2;
	assign result_bits = res_s2;
endmodule

// File: design/dri_checker.sv
// Port checker for the round-to-integral block, bound to the top level
`include "double_round_to_integral_macros.svh"
module dri_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] result_bits
);
	`DRI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result_bits))
	`DRI_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)
	`DRI_ASSERT_NEXT(a_accept_yields, clk, arst_n, in_valid && in_ready && !out_valid, ##1 out_valid)
endmodule

bind double_round_to_integral dri_checker u_dri_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .result_bits(result_bits)
);

// File: test/double_round_to_integral_tb.sv
// Testbench for the round-to-integral block: directed and random words checked by a scoreboard
`timescale 1ns / 1ps
module double_round_to_integral_tb;
	import dri_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [63:0] value_bits;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] result_bits;

	int idle_pct;
	int stall_pct;

	class rounding_board;
		logic [63:0] pending_q[$];
		int errors;
		int mismatches;

		function logic [63:0] integral_of(logic [63:0] bits, op_t op);
			logic [10:0] ex;
			logic [63:0] sign;
			logic [63:0] step;
			logic [63:0] frac_mask;
			logic [63:0] trunc_part;
			logic        bump;
			int          nfrac;
			ex = bits[62:52];
			sign = {bits[63], 63'd0};
			if (ex >= 11'd1075 || bits[62:0] == 63'd0) begin
				return bits;
			end
			if (ex < 11'd1023) begin
				case (op)
					OP_FLOOR: bump = bits[63];
					OP_CEIL: bump = !bits[63];
					OP_TRUNC: bump = 1'b0;
					default: bump = (ex == 11'd1022);
				endcase
				return sign | (bump ? OneBits : 64'd0);
			end
			nfrac = 1075 - int'(ex);
			step = 64'd1 << nfrac;
			frac_mask = step - 64'd1;
			if ((bits & frac_mask) == 64'd0) begin
				return bits;
			end
			trunc_part = bits & ~frac_mask;
			case (op)
				OP_FLOOR: bump = bits[63];
				OP_CEIL: bump = !bits[63];
				OP_TRUNC: bump = 1'b0;
				default: bump = bits[nfrac - 1];
			endcase
			return bump ? trunc_part + step : trunc_part;
		endfunction

		function void note_word(logic [1:0] op, logic [63:0] bits);
			pending_q.push_back(integral_of(bits, op_t'(op)));
		endfunction

		function void check_word(logic [63:0] got);
			logic [63:0] want;
			if (pending_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result %h", got);
				return;
			end
			want = pending_q.pop_front();
			if (got !== want) begin
				errors++;
				if (mismatches++ < 10)
					$display("result_bits mismatch: expected %h actual %h", want, got);
			end
		endfunction
	endclass

	rounding_board board;

	double_round_to_integral DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .value_bits(value_bits),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_bits(result_bits)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) board.note_word(operation, value_bits);
		if (arst_n && out_valid && out_ready) board.check_word(result_bits);
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_word(logic [1:0] op, logic [63:0] bits);
		while (($urandom_range(99) < idle_pct)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		value_bits <= bits;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [63:0] random_double();
		logic [63:0] bits;
		logic [10:0] ex;
		bits = {$urandom, $urandom};
		case ($urandom_range(9))
			0: ex = bits[62:52];
			1: ex = 11'($urandom_range(1020, 1022));
			2: ex = 11'($urandom_range(1075, 1080));
			3: ex = 11'h7FF;
			default: ex = 11'($urandom_range(1023, 1074));
		endcase
		bits[62:52] = ex;
		if ($urandom_range(7) == 0) bits[51:0] = bits[51:0] & ~(52'hF_FFFF_FFFF_FFFF >> ex[5:0]);
		return bits;
	endfunction

	initial begin
		logic [63:0] directed[$];
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = 2'd0;
		value_bits = 64'd0;
		out_ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
			64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
			64'h3FDF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
			64'h8000_0000_0000_0001, 64'h3FF8_0000_0000_0000,
			64'hC004_0000_0000_0000, 64'h433F_FFFF_FFFF_FFFF,
			64'hC32F_FFFF_FFFF_FFFF, 64'h4330_0000_0000_0001,
			64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0001,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000};
		foreach (directed[i]) begin
			send_word(OP_FLOOR, directed[i]);
			send_word(OP_CEIL, directed[i]);
			send_word(OP_TRUNC, directed[i]);
			send_word(OP_ROUND, directed[i]);
		end
		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = (phase == 1) ? 57 : (phase == 3) ? 35 : 0;
			stall_pct = (phase == 2) ? 57 : (phase == 3) ? 35 : 0;
			repeat (100) send_word(2'($urandom_range(3)), random_double());
		end
		in_valid <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		while (board.pending_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("FAILURE");
		$finish;
	end
endmodule

// File: double_round_to_integral.f
+incdir+design
design/dri_pkg.sv
design/dri_core.sv
design/double_round_to_integral.sv
design/dri_checker.sv
test/double_round_to_integral_tb.sv
